// File: rtl/burst_then_moving_average_assert.svh
// Assertion macros for the burst_then_moving_average block.
// Included by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef BURST_THEN_MOVING_AVERAGE_ASSERT_SVH
`define BURST_THEN_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BTMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BTMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/btma_pkg.sv
// Shared widths and defaults for the burst decimator / moving average block.
// No dependencies.
`timescale 1ns / 1ps

package btma_pkg;

    localparam int SAMPLE_W     = 12;   // ADC sample and burst mean width
    localparam int BSUM_W       = 16;   // burst accumulator width
    localparam int BURST_LOG2   = 4;    // 16 samples per burst
    localparam int BCNT_W       = 4;
    localparam int WSUM_W       = 20;   // window sum width
    localparam int WINDOW_DEF   = 16;
    localparam int QUEUE_DEPTH  = 2;    // burst means between front and back

    typedef logic [SAMPLE_W-1:0] t_sample;

endpackage

// File: rtl/btma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module btma_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/btma_front.sv
// Front end: takes samples, sums each burst of 16 and emits the burst mean.
// Depends on btma_pkg.
`timescale 1ns / 1ps

module btma_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sample_valid,
    output logic              o_sample_ready,
    input  btma_pkg::t_sample i_sample,
    input  logic              i_queue_full,
    output logic              o_push,
    output btma_pkg::t_sample o_mean
);

    logic [btma_pkg::BCNT_W-1:0] r_count, n_count;
    logic [btma_pkg::BSUM_W-1:0] r_sum, n_sum;
    logic [btma_pkg::BSUM_W-1:0] w_sum_inc;
    logic                        w_last;
    logic                        w_xfer;

    // only the burst-closing sample needs a free queue slot
    assign w_last         = (r_count == {btma_pkg::BCNT_W{1'b1}});
    assign o_sample_ready = !(w_last && i_queue_full);
    assign w_xfer         = i_sample_valid && o_sample_ready;

    assign w_sum_inc = r_sum + btma_pkg::BSUM_W'(i_sample);
    assign o_push    = w_xfer && w_last;
    assign o_mean    = w_sum_inc[btma_pkg::BURST_LOG2 +: btma_pkg::SAMPLE_W];

    // burst accumulator, cleared when the burst closes
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (w_xfer) begin
            n_count = r_count + 1'b1;
            n_sum   = w_last ? '0 : w_sum_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

// File: rtl/btma_queue.sv
// Small FIFO of burst means between the front and back ends.
// Depends on btma_pkg.
`timescale 1ns / 1ps

module btma_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  btma_pkg::t_sample i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output btma_pkg::t_sample o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    btma_pkg::t_sample r_mem [DEPTH];
    logic [PW-1:0]     r_wr, n_wr;
    logic [PW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // pointer and occupancy update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/btma_back.sv
// Back end: window ring of burst means, running window sum, and the divide
// by WINDOW as a reciprocal multiply. Depends on btma_pkg and btma_ram.
`timescale 1ns / 1ps

module btma_back #(
    parameter int WINDOW = btma_pkg::WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_queue_empty,
    input  btma_pkg::t_sample i_queue_data,
    output logic              o_pop,
    output logic              o_average_valid,
    input  logic              i_average_ready,
    output btma_pkg::t_sample o_average
);

    localparam int PW        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WS        = btma_pkg::WSUM_W;
    localparam int MULT_W    = WS + 1;
    localparam int PROD_W    = WS + MULT_W;
    // floor(x / WINDOW) == (x * DIV_MULT) >> DIV_SHIFT for every x below 2**WS
    localparam int DIV_SHIFT = WS + $clog2(WINDOW);
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [PW-1:0]     r_pos, n_pos;
    logic              r_filled, n_filled;
    logic [WS-1:0]     r_wsum, n_wsum;
    btma_pkg::t_sample r_mean;
    logic [PROD_W-1:0] r_prod;
    logic              r_out_valid, n_out_valid;
    btma_pkg::t_sample r_avg;

    logic              w_ram_we;
    logic              w_ram_re;
    btma_pkg::t_sample w_ram_rdata;
    btma_pkg::t_sample w_old;
    logic              w_out_load;

    btma_ram #(
        .WIDTH (btma_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_mean),
        .i_re    (w_ram_re),
        .i_raddr (r_pos),
        .o_rdata (w_ram_rdata)
    );

    // entries not yet written on the first lap read as zero
    assign w_old      = r_filled ? w_ram_rdata : '0;
    assign o_pop      = (r_state == ST_IDLE) && !i_queue_empty;
    assign w_ram_re   = o_pop;
    assign w_ram_we   = (r_state == ST_UPD);
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || i_average_ready);

    // sequencer: pop, replace oldest entry, multiply, hand to output register
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_filled    = r_filled;
        n_wsum      = r_wsum;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_average_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (!i_queue_empty) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_wsum = r_wsum - WS'(w_old) + WS'(r_mean);
                if (r_pos == PW'(WINDOW - 1)) begin
                    n_pos    = '0;
                    n_filled = 1'b1;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_filled    <= 1'b0;
            r_wsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_filled    <= n_filled;
            r_wsum      <= n_wsum;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mean <= i_queue_data;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_wsum) * PROD_W'(DIV_MULT);
        end
        if (w_out_load) begin
            r_avg <= r_prod[DIV_SHIFT +: btma_pkg::SAMPLE_W];
        end
    end

    assign o_average_valid = r_out_valid;
    assign o_average       = r_avg;

endmodule

// File: rtl/burst_then_moving_average.sv
// Top level: burst decimator followed by a moving average over WINDOW means.
// Depends on btma_pkg, btma_front, btma_queue, btma_back, btma_ram and the
// assertion header.
//
//   channel   handshake                          payload
//   input     i_sample_valid / o_sample_ready    i_sample  [11:0]
//   output    o_average_valid / i_average_ready  o_average [11:0]
//
// One sample is taken every cycle, save that a burst-closing sample waits while
// the queue is full; every 16th sample closes a burst. A burst mean reaches
// o_average_valid through the back-end sequence: RAM read, window update, multiply, output.
// A two-entry mean queue separates the halves, so a stalled output only holds
// off the burst-closing sample once the queue is full.
// Reset (synchronous, active low) clears all control state; window entries
// not yet written on the first lap are read as zero.
`timescale 1ns / 1ps
`include "burst_then_moving_average_assert.svh"

module burst_then_moving_average #(
    parameter int WINDOW = btma_pkg::WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sample_valid,
    output logic              o_sample_ready,
    input  btma_pkg::t_sample i_sample,
    output logic              o_average_valid,
    input  logic              i_average_ready,
    output btma_pkg::t_sample o_average
);

    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    btma_pkg::t_sample w_mean;
    btma_pkg::t_sample w_q_data;

    btma_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .i_queue_full   (w_full),
        .o_push         (w_push),
        .o_mean         (w_mean)
    );

    btma_queue #(
        .DEPTH (btma_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_mean),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_q_data)
    );

    btma_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_queue_empty   (w_empty),
        .i_queue_data    (w_q_data),
        .o_pop           (w_pop),
        .o_average_valid (o_average_valid),
        .i_average_ready (i_average_ready),
        .o_average       (o_average)
    );

    // queue never overflows or underflows; means come only from accepted samples
    `BTMA_ASSERT_NOW(a_no_push_full, w_push, !w_full, "mean pushed into full queue")
    `BTMA_ASSERT_NOW(a_no_pop_empty, w_pop, !w_empty, "mean popped from empty queue")
    `BTMA_ASSERT_NOW(a_push_on_xfer, w_push, i_sample_valid && o_sample_ready, "push without transfer")
    `BTMA_ASSERT_NEXT(a_pop_busy, w_pop, !w_pop, "back end popped twice in a row")

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for burst_then_moving_average: a directed table, then random
// bursts, with a built-in predictor of the burst mean and the window average.
// Depends on btma_pkg and the burst_then_moving_average RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int WIN          = btma_pkg::WINDOW_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 20;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int N_ROWS       = 25;

    // Sample patterns, chosen once per burst in the random part
    typedef enum int {FILL_FULL, FILL_MAX, FILL_ZERO, FILL_LOW, FILL_BIT} t_fill;

    // One row of the directed table; average is used only where typed is set
    typedef struct packed {
        btma_pkg::t_sample sample;
        logic              typed;
        btma_pkg::t_sample average;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_sample_valid;
    logic              o_sample_ready;
    btma_pkg::t_sample i_sample;
    logic              o_average_valid;
    logic              i_average_ready;
    btma_pkg::t_sample o_average;

    // Predictor state
    logic [btma_pkg::BSUM_W-1:0] acc_sum;
    logic [btma_pkg::BCNT_W-1:0] acc_count;
    btma_pkg::t_sample           mean_ring [WIN];
    logic [btma_pkg::WSUM_W-1:0] ring_sum;
    int                          ring_pos;

    btma_pkg::t_sample avg_expected[$];
    int                n_errors;
    int                n_results;

    // A first burst of full-scale samples after reset gives mean 4095, and the
    // window holds one 4095 among fifteen zeros: 4095 / 16 = 255.
    // The rest opens the next burst with edge and alternating bit patterns.
    t_row dir_rows [N_ROWS] = '{
        '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0},
        '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0},
        '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0},
        '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0},
        '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0},
        '{12'hFFF, 1'b1, 12'd255},
        '{12'h000, 1'b0, 12'd0}, '{12'h001, 1'b0, 12'd0}, '{12'h800, 1'b0, 12'd0},
        '{12'h555, 1'b0, 12'd0}, '{12'hAAA, 1'b0, 12'd0}, '{12'h7FF, 1'b0, 12'd0},
        '{12'hFFE, 1'b0, 12'd0}, '{12'hFFF, 1'b0, 12'd0}, '{12'h000, 1'b0, 12'd0}
    };

    burst_then_moving_average dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sample_valid  (i_sample_valid),
        .o_sample_ready  (o_sample_ready),
        .i_sample        (i_sample),
        .o_average_valid (o_average_valid),
        .i_average_ready (i_average_ready),
        .o_average       (o_average)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAIL burst_then_moving_average");
        $finish;
    end

    task automatic report_mismatch(input string what, input btma_pkg::t_sample got,
                                   input btma_pkg::t_sample want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    function automatic void clear_window();
        acc_sum   = '0;
        acc_count = '0;
        ring_sum  = '0;
        ring_pos  = 0;
        for (int k = 0; k < WIN; k++) mean_ring[k] = '0;
    endfunction

    // Takes one sample; returns 1 with the window average when it closes a burst
    function automatic bit fold_sample(input btma_pkg::t_sample s,
                                       output btma_pkg::t_sample avg);
        btma_pkg::t_sample mean;
        acc_sum   = acc_sum + s;
        acc_count = acc_count + 1'b1;
        avg       = '0;
        if (acc_count != '0)
            return 1'b0;
        mean     = btma_pkg::t_sample'(acc_sum >> btma_pkg::BURST_LOG2);
        acc_sum  = '0;
        ring_sum = ring_sum - mean_ring[ring_pos] + mean;
        mean_ring[ring_pos] = mean;
        ring_pos = (ring_pos + 1) % WIN;
        avg      = btma_pkg::t_sample'(ring_sum / WIN);
        return 1'b1;
    endfunction

    function automatic btma_pkg::t_sample make_sample(input t_fill f);
        case (f)
            FILL_MAX:  return '1;
            FILL_ZERO: return '0;
            FILL_LOW:  return btma_pkg::t_sample'($urandom_range(0, 15));
            FILL_BIT:  return btma_pkg::t_sample'(
                                  1 << $urandom_range(0, btma_pkg::SAMPLE_W - 1))
                              ^ ($urandom_range(0, 1) ? '1 : '0);
            default:   return btma_pkg::t_sample'($urandom);
        endcase
    endfunction

    function automatic t_fill pick_fill(input int burst_idx);
        int r;
        // long full-scale stretch drives the window to 4095, then a short drop
        if (burst_idx >= 30 && burst_idx < 48) return FILL_MAX;
        if (burst_idx >= 48 && burst_idx < 52) return FILL_ZERO;
        r = $urandom_range(0, 9);
        case (r)
            5:       return FILL_MAX;
            6:       return FILL_ZERO;
            7:       return FILL_LOW;
            8:       return FILL_BIT;
            default: return FILL_FULL;
        endcase
    endfunction

    // Drives one sample and waits for its transfer; called at a clock edge
    task automatic send_sample(input btma_pkg::t_sample v, input logic typed,
                               input btma_pkg::t_sample typed_avg, input int gap);
        btma_pkg::t_sample avg;
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= v;
        do @(posedge i_clk); while (!o_sample_ready);
        if (fold_sample(v, avg))
            avg_expected.push_back(typed ? typed_avg : avg);
    endtask

    // Sender holds off until every pending average has come out
    task automatic hold_until_drained();
        i_sample_valid <= 1'b0;
        @(posedge i_clk);
        while (avg_expected.size() != 0) @(posedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        btma_pkg::t_sample want;
        if (i_rst_n && o_average_valid && i_average_ready) begin
            n_results++;
            if (avg_expected.size() == 0) begin
                report_mismatch("average with none pending", o_average, '0);
            end else begin
                want = avg_expected.pop_front();
                if (o_average !== want)
                    report_mismatch("average", o_average, want);
            end
        end
    end

    // Result side: random stalls per transfer, with stall-free stretches
    initial begin
        int w;
        i_average_ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            w = ((n_results / 8) % 3 == 0) ? 0 : $urandom_range(0, 15);
            if (w > 0) begin
                i_average_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_average_ready <= 1'b1;
            do @(posedge i_clk); while (!o_average_valid);
        end
    end

    // Sample side and end of run
    initial begin
        t_fill fill;
        int    burst_idx;
        int    spins;
        i_rst_n        <= 1'b0;
        i_sample_valid <= 1'b0;
        i_sample       <= '0;
        n_errors  = 0;
        n_results = 0;
        clear_window();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: first rows back to back, the rest with gaps
        for (int i = 0; i < N_ROWS; i++)
            send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].average,
                        (i < 8) ? 0 : $urandom_range(0, 15));
        hold_until_drained();

        // random bursts
        fill      = FILL_FULL;
        burst_idx = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (acc_count == '0) begin
                burst_idx++;
                fill = pick_fill(burst_idx);
            end
            if (n == RANDOM_ITEMS / 2)
                hold_until_drained();
            send_sample(make_sample(fill), 1'b0, '0,
                        (burst_idx % 6 == 0) ? 0 : $urandom_range(0, 15));
        end
        i_sample_valid <= 1'b0;

        spins = 0;
        while (avg_expected.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (avg_expected.size() != 0)
            report_mismatch("averages never delivered", '0,
                            btma_pkg::t_sample'(avg_expected.size()));

        if (n_errors == 0)
            $display("PASS burst_then_moving_average");
        else
            $display("FAIL burst_then_moving_average");
        $finish;
    end

endmodule
